// ===== hdl/obc_pkg.sv =====
// ----------------------------------------------------------------------------
// obc_pkg: oriented box containment shared definitions
// Fixed formats, CORDIC angle table and rounding helper for the sine/cosine
// pipeline and the containment datapath.
// ----------------------------------------------------------------------------
package obc_pkg;

  // Phase word: one full turn is 2^PHASE_W.
  localparam int unsigned PHASE_W = 32;
  localparam logic [PHASE_W-1:0] EIGHTH_TURN = 32'h2000_0000;

  // CORDIC datapath, Q30 with headroom.
  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned CORDIC_W = 34;

  // Trig outputs are Q1.15, clamped to +/-TRIG_LIMIT.
  localparam int unsigned TRIG_W = 17;
  localparam int unsigned FRAC_SHIFT = 15;
  localparam int unsigned Q15_HALF = 16384;

  typedef logic signed [CORDIC_W-1:0] cordic_t;
  typedef logic signed [TRIG_W-1:0] trig_t;

  localparam cordic_t CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam trig_t TRIG_LIMIT = 17'sd32767;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  // round(atan(2^-i) * 2^32 / (2*pi))
  localparam cordic_t ATAN_PHASE [CORDIC_STEPS] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331, 34'sd21354465, 34'sd10679838, 34'sd5340245,
    34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772, 34'sd166886,
    34'sd83443, 34'sd41722, 34'sd20861, 34'sd10430, 34'sd5215,
    34'sd2608, 34'sd1304, 34'sd652, 34'sd326, 34'sd163,
    34'sd81, 34'sd41, 34'sd20, 34'sd10, 34'sd5, 34'sd3, 34'sd1
  };

  // Round a Q30 value to Q15 and clamp to the symmetric trig range.
  function automatic trig_t to_q15(input cordic_t v);
    cordic_t t;
    logic signed [CORDIC_W-FRAC_SHIFT-1:0] r;
    t = v + cordic_t'(Q15_HALF);
    r = t[CORDIC_W-1:FRAC_SHIFT];
    if (r > TRIG_LIMIT) begin
      return TRIG_LIMIT;
    end else if (r < -TRIG_LIMIT) begin
      return -TRIG_LIMIT;
    end
    return trig_t'(r);
  endfunction

endpackage

// ===== hdl/obc_in_if.sv =====
// ----------------------------------------------------------------------------
// obc_in_if: query channel
// Valid/ready channel carrying one point, box center, heading and extents.
// ----------------------------------------------------------------------------
interface obc_in_if #(
  parameter int unsigned COORD_BITS = 32,
  parameter int unsigned ANGLE_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic signed [COORD_BITS-1:0] center_z;
  logic [ANGLE_BITS-1:0]        center_heading;
  logic [COORD_BITS-2:0]        half_x;
  logic [COORD_BITS-2:0]        half_y;
  logic [COORD_BITS-2:0]        half_z;

  modport source (
    output valid, point_x, point_y, point_z, center_x, center_y, center_z,
           center_heading, half_x, half_y, half_z,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, point_z, center_x, center_y, center_z,
           center_heading, half_x, half_y, half_z,
    output ready
  );
endinterface

// ===== hdl/obc_out_if.sv =====
// ----------------------------------------------------------------------------
// obc_out_if: result channel
// Valid/ready channel carrying the containment flag.
// ----------------------------------------------------------------------------
interface obc_out_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (
    output valid, inside_res,
    input  ready
  );

  modport sink (
    input  valid, inside_res,
    output ready
  );
endinterface

// ===== hdl/obc_cordic.sv =====
// ----------------------------------------------------------------------------
// obc_cordic: pipelined sine/cosine
// One rotation-mode CORDIC step per register stage, then a rounding and
// quadrant-fold stage.
// ----------------------------------------------------------------------------
module obc_cordic
  import obc_pkg::*;
(
  input  logic    clk_i,
  input  logic    en_i,
  input  cordic_t z_i,
  input  quad_e   quad_i,
  output trig_t   cos_o,
  output trig_t   sin_o
);

  cordic_t x_q [CORDIC_STEPS];
  cordic_t y_q [CORDIC_STEPS];
  cordic_t z_q [CORDIC_STEPS];
  quad_e   q_q [CORDIC_STEPS];
  trig_t   cos_q;
  trig_t   sin_q;
  trig_t   cs;
  trig_t   sn;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    cordic_t x_in;
    cordic_t y_in;
    cordic_t z_in;
    quad_e   q_in;
    cordic_t xs;
    cordic_t ys;

    if (k == 0) begin : g_first
      assign x_in = CORDIC_GAIN_Q30;
      assign y_in = '0;
      assign z_in = z_i;
      assign q_in = quad_i;
    end else begin : g_next
      assign x_in = x_q[k-1];
      assign y_in = y_q[k-1];
      assign z_in = z_q[k-1];
      assign q_in = q_q[k-1];
    end

    assign xs = x_in >>> k;
    assign ys = y_in >>> k;

    // Rotate toward zero residual angle.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_in[CORDIC_W-1]) begin
          x_q[k] <= x_in - ys;
          y_q[k] <= y_in + xs;
          z_q[k] <= z_in - ATAN_PHASE[k];
        end else begin
          x_q[k] <= x_in + ys;
          y_q[k] <= y_in - xs;
          z_q[k] <= z_in + ATAN_PHASE[k];
        end
        q_q[k] <= q_in;
      end
    end
  end

  assign cs = to_q15(x_q[CORDIC_STEPS-1]);
  assign sn = to_q15(y_q[CORDIC_STEPS-1]);

  // Fold the first-quadrant result back to the full circle.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      case (q_q[CORDIC_STEPS-1])
        QUAD_1: begin
          cos_q <= -sn;
          sin_q <= cs;
        end
        QUAD_2: begin
          cos_q <= -cs;
          sin_q <= -sn;
        end
        QUAD_3: begin
          cos_q <= sn;
          sin_q <= -cs;
        end
        default: begin
          cos_q <= cs;
          sin_q <= sn;
        end
      endcase
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

// ===== hdl/oriented_box_containment.sv =====
// ----------------------------------------------------------------------------
// oriented_box_containment: point in oriented bounding box test
// Tests each point against a box rotated about the vertical axis and returns
// one flag per query.
// ----------------------------------------------------------------------------
// The block takes one query transaction per clock unless the output stalls, and
// returns one result transaction per query, in order. A query passes through
// one input stage, 30 CORDIC step stages, one sine/cosine rounding stage, one
// multiply stage, one sum stage and the output register, 35 registers in all;
// the pipeline of one CORDIC step per stage sets that depth.
// While the output holds a result that is not taken, the whole pipeline holds
// and in_i.ready is low.
// The heading is a fraction of a full turn; sine and cosine are formed to
// Q1.15, the offset from the center saturates to the coordinate width, the
// rotated offsets are rounded and saturated, and the flag is set when each
// absolute local offset is no greater than its half-extent.
// ----------------------------------------------------------------------------
module oriented_box_containment
  import obc_pkg::*;
#(
  parameter int unsigned COORD_BITS = 32,
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  obc_in_if.sink       in_i,
  obc_out_if.source    out_o
);

  localparam int unsigned CW    = COORD_BITS;
  localparam int unsigned PW    = CW + TRIG_W;          // product width
  localparam int unsigned SW    = PW + 1 - FRAC_SHIFT;  // rounded sum width
  localparam int unsigned CL    = CORDIC_STEPS + 1;     // CORDIC latency
  localparam int unsigned S_OUT = CL + 3;
  localparam int unsigned NSTG  = S_OUT + 1;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [CW-2:0]        half_t;
  typedef logic signed [PW-1:0] prod_t;

  // Saturate a one-bit-grown difference to the coordinate width.
  function automatic coord_t sat_diff(input logic signed [CW:0] v);
    if (v[CW] != v[CW-1]) begin
      return {v[CW], {(CW-1){~v[CW]}}};
    end
    return v[CW-1:0];
  endfunction

  // Round a Q15-scaled sum and saturate to the coordinate width.
  function automatic coord_t rot_sum(input logic signed [PW:0] v);
    logic signed [PW:0]   t;
    logic signed [SW-1:0] sh;
    logic [SW-CW:0]       top;
    t   = v + (PW+1)'(Q15_HALF);
    sh  = t[PW:FRAC_SHIFT];
    top = sh[SW-1:CW-1];
    if (!((&top) || (~|top))) begin
      return {sh[SW-1], {(CW-1){~sh[SW-1]}}};
    end
    return sh[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] mag(input coord_t v);
    return v[CW-1] ? CW'(-v) : CW'(v);
  endfunction

  // Advance everything unless a finished result waits at the output.
  logic            adv;
  logic [NSTG-1:0] vld_q;

  assign adv        = !vld_q[S_OUT] || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-2:0], in_i.valid};
    end
  end

  // Input stage: offsets and phase reduction.
  logic signed [CW:0]   dfx, dfy, dfz;
  logic [PHASE_W-1:0]   phase;
  logic [PHASE_W-1:0]   pq;
  quad_e                quad;
  logic [PHASE_W-1:0]   resid;

  assign dfx   = {in_i.point_x[CW-1], in_i.point_x} - {in_i.center_x[CW-1], in_i.center_x};
  assign dfy   = {in_i.point_y[CW-1], in_i.point_y} - {in_i.center_y[CW-1], in_i.center_y};
  assign dfz   = {in_i.point_z[CW-1], in_i.point_z} - {in_i.center_z[CW-1], in_i.center_z};
  assign phase = {in_i.center_heading, {(PHASE_W-ANGLE_BITS){1'b0}}};
  assign pq    = phase + EIGHTH_TURN;
  assign quad  = quad_e'(pq[PHASE_W-1 -: 2]);
  // Residual angle in [-1/8, 1/8) turn.
  assign resid = {phase[PHASE_W-1 -: 2] - pq[PHASE_W-1 -: 2], phase[PHASE_W-3:0]};

  coord_t  dx0_q, dy0_q, dz0_q;
  half_t   hx0_q, hy0_q, hz0_q;
  cordic_t z0_q;
  quad_e   q0_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx0_q <= sat_diff(dfx);
      dy0_q <= sat_diff(dfy);
      dz0_q <= sat_diff(dfz);
      hx0_q <= in_i.half_x;
      hy0_q <= in_i.half_y;
      hz0_q <= in_i.half_z;
      z0_q  <= cordic_t'($signed(resid));
      q0_q  <= quad;
    end
  end

  // Sine and cosine, CL stages deep.
  trig_t cos_w, sin_w;

  obc_cordic u_cordic (
    .clk_i  (clk_i),
    .en_i   (adv),
    .z_i    (z0_q),
    .quad_i (q0_q),
    .cos_o  (cos_w),
    .sin_o  (sin_w)
  );

  // Delay line alongside the CORDIC; the vertical test resolves in its
  // first stage so only its flag travels on.
  coord_t dx_q  [1:CL];
  coord_t dy_q  [1:CL];
  half_t  hx_q  [1:CL];
  half_t  hy_q  [1:CL];
  logic   zok_q [1:CL];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q[1]  <= dx0_q;
      dy_q[1]  <= dy0_q;
      hx_q[1]  <= hx0_q;
      hy_q[1]  <= hy0_q;
      zok_q[1] <= mag(dz0_q) <= {1'b0, hz0_q};
      for (int k = 2; k <= CL; k++) begin
        dx_q[k]  <= dx_q[k-1];
        dy_q[k]  <= dy_q[k-1];
        hx_q[k]  <= hx_q[k-1];
        hy_q[k]  <= hy_q[k-1];
        zok_q[k] <= zok_q[k-1];
      end
    end
  end

  // Multiply stage: four coordinate by Q15 products.
  prod_t pxc_q, pys_q, pyc_q, pxs_q;
  half_t hxm_q, hym_q;
  logic  zokm_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pxc_q  <= prod_t'(dx_q[CL]) * prod_t'(cos_w);
      pys_q  <= prod_t'(dy_q[CL]) * prod_t'(sin_w);
      pyc_q  <= prod_t'(dy_q[CL]) * prod_t'(cos_w);
      pxs_q  <= prod_t'(dx_q[CL]) * prod_t'(sin_w);
      hxm_q  <= hx_q[CL];
      hym_q  <= hy_q[CL];
      zokm_q <= zok_q[CL];
    end
  end

  // Sum stage: lx = dx*cos + dy*sin, ly = dy*cos - dx*sin.
  coord_t lx_q, ly_q;
  half_t  hxs_q, hys_q;
  logic   zoks_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lx_q   <= rot_sum({pxc_q[PW-1], pxc_q} + {pys_q[PW-1], pys_q});
      ly_q   <= rot_sum({pyc_q[PW-1], pyc_q} - {pxs_q[PW-1], pxs_q});
      hxs_q  <= hxm_q;
      hys_q  <= hym_q;
      zoks_q <= zokm_q;
    end
  end

  // Output register: compare against the half-extents.
  logic inside_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      inside_q <= (mag(lx_q) <= {1'b0, hxs_q}) && (mag(ly_q) <= {1'b0, hys_q}) && zoks_q;
    end
  end

  assign out_o.valid      = vld_q[S_OUT];
  assign out_o.inside_res = inside_q;

endmodule
